// ===== rtl/core/tccs_pkg.sv =====
// shared types and constants for the text console cursor and scroll engine
// no dependencies; used by the interfaces and every module of the block
`timescale 1ns / 1ps

package tccs_pkg;

  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int IDX_W  = 11;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;

  localparam int TAB_STEP = 8;

  localparam logic [CELL_W-1:0] BLANK_RESET = 16'h0F20;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [2:0] {
    K_NOP,
    K_BS,
    K_TAB,
    K_CR,
    K_LF,
    K_PRINT,
    K_CLEAR,
    K_READ
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [CELL_W-1:0]  cell_data;
    logic [IDX_W-1:0]   read_index;
  } qent_t;

  typedef struct packed {
    logic  push;
    qent_t ent;
  } q_wr_t;

  typedef struct packed {
    logic  valid;
    qent_t ent;
  } q_rd_t;

  typedef struct packed {
    logic [IDX_W-1:0]  cursor_position;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic              scrolled;
    logic              cell_written;
    logic [IDX_W-1:0]  cell_index;
    logic [CELL_W-1:0] cell_value;
  } res_t;

endpackage

// ===== rtl/core/tccs_cmd_if.sv =====
// command channel: valid/ready handshake with the request fields
// depends on tccs_pkg
`timescale 1ns / 1ps

interface tccs_cmd_if;
  import tccs_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [CHAR_W-1:0] char_code;
  logic [ATTR_W-1:0] attribute;
  logic [IDX_W-1:0]  read_index;

  modport source (output valid, command, char_code, attribute, read_index, input ready);
  modport sink (input valid, command, char_code, attribute, read_index, output ready);
endinterface

// ===== rtl/core/tccs_res_if.sv =====
// result channel: valid/ready handshake with cursor and cell report
// depends on tccs_pkg
`timescale 1ns / 1ps

interface tccs_res_if;
  import tccs_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  cursor_position;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic              scrolled;
  logic              cell_written;
  logic [IDX_W-1:0]  cell_index;
  logic [CELL_W-1:0] cell_value;

  modport source (output valid, cursor_position, cursor_col, cursor_row, scrolled,
                  cell_written, cell_index, cell_value, input ready);
  modport sink (input valid, cursor_position, cursor_col, cursor_row, scrolled,
                cell_written, cell_index, cell_value, output ready);
endinterface

// ===== rtl/core/tccs_cfg_if.sv =====
// configuration write channel carrying the blank cell value
// depends on tccs_pkg
`timescale 1ns / 1ps

interface tccs_cfg_if;
  import tccs_pkg::*;

  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] blank_cell;

  modport source (output valid, blank_cell, input ready);
  modport sink (input valid, blank_cell, output ready);
endinterface

// ===== rtl/core/tccs_front.sv =====
// front end: takes requests, decodes command and character class, pushes to queue
// depends on tccs_pkg and tccs_cmd_if
`timescale 1ns / 1ps

module tccs_front (
  tccs_cmd_if.sink      in_ch,
  input  logic          q_full,
  input  logic          init_busy,
  output tccs_pkg::q_wr_t q_wr
);
  import tccs_pkg::*;

  kind_t kind;

  assign in_ch.ready = !q_full && !init_busy;

  always_comb begin
    kind = K_NOP;
    unique case (in_ch.command)
      CMD_PUT: begin
        priority if (in_ch.char_code == CH_BS) kind = K_BS;
        else if (in_ch.char_code == CH_TAB) kind = K_TAB;
        else if (in_ch.char_code == CH_CR) kind = K_CR;
        else if (in_ch.char_code == CH_LF) kind = K_LF;
        else if (in_ch.char_code >= CH_PRINT_LO && in_ch.char_code <= CH_PRINT_HI)
          kind = K_PRINT;
        else kind = K_NOP;
      end
      CMD_CLEAR: kind = K_CLEAR;
      CMD_READ:  kind = K_READ;
      default:   kind = K_NOP;
    endcase
  end

  assign q_wr.push           = in_ch.valid && in_ch.ready;
  assign q_wr.ent.kind       = kind;
  assign q_wr.ent.cell_data  = {in_ch.attribute, in_ch.char_code};
  assign q_wr.ent.read_index = in_ch.read_index;

endmodule

// ===== rtl/core/tccs_queue.sv =====
// short fifo of decoded requests between front end and back end
// depends on tccs_pkg
`timescale 1ns / 1ps

module tccs_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  tccs_pkg::q_wr_t q_wr,
  output logic            q_full,
  output tccs_pkg::q_rd_t q_rd,
  input  logic            q_pop
);
  import tccs_pkg::*;

  qent_t            ent_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r;
  logic [Q_AW-1:0]  rd_ptr_r;
  logic [Q_AW:0]    cnt_r;
  logic             do_push;
  logic             do_pop;

  assign q_full   = cnt_r == (Q_AW+1)'(Q_DEPTH);
  assign q_rd.valid = cnt_r != '0;
  assign q_rd.ent   = ent_r[rd_ptr_r];
  assign do_push  = q_wr.push && !q_full;
  assign do_pop   = q_pop && q_rd.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= q_wr.ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> !q_full)
    else $error("request pushed into full queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ===== rtl/core/tccs_back.sv =====
// back end: cursor state, screen store, scroll and clear sweeps, result register
// depends on tccs_pkg, tccs_cfg_if and tccs_res_if
`timescale 1ns / 1ps

module tccs_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tccs_pkg::q_rd_t q_rd,
  output logic            q_pop,
  output logic            init_busy,
  tccs_cfg_if.sink        cfg_ch,
  tccs_res_if.source      out_ch
);
  import tccs_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int LAST  = (ROWS - 1) * COLUMNS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCROLL,
    S_FILL,
    S_DONE
  } state_t;

  state_t            state_r;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic [CW-1:0]     k_r;
  logic [CELL_W-1:0] fill_val_r;
  logic              init_r;
  logic [CELL_W-1:0] blank_r;
  logic              rd_ok_r;
  res_t              res_r;
  res_t              out_r;
  logic              out_valid_r;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] mem_rd_r;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [CELL_W-1:0] mem_wd;
  logic [AW-1:0]     mem_ra;

  logic              out_free;
  logic              out_load;
  logic [COL_W:0]    nc;
  logic [ROW_W:0]    nr;
  logic [COL_W-1:0]  nx_col;
  logic [ROW_W-1:0]  nx_row;
  logic              nx_scroll;
  logic [AW-1:0]     pos_cur;
  logic [AW-1:0]     pos_nx;
  logic              read_ok;
  logic              is_print;
  res_t              put_res;
  res_t              read_res;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign q_pop     = (state_r == S_IDLE) && q_rd.valid && out_free;
  assign init_busy = init_r;
  assign cfg_ch.ready = 1'b1;

  // result register loads on a put or ignored command without scroll, or when a long request completes
  assign out_load = (q_pop && q_rd.ent.kind != K_CLEAR && q_rd.ent.kind != K_READ &&
                     !nx_scroll) || (state_r == S_DONE && out_free);

  // cursor update for a put
  always_comb begin
    nc = {1'b0, col_r};
    nr = {1'b0, row_r};
    unique case (q_rd.ent.kind)
      K_BS: begin
        if (col_r != '0) nc = nc - 1'b1;
      end
      K_TAB: nc = (nc + (COL_W+1)'(TAB_STEP)) & ~(COL_W+1)'(TAB_STEP - 1);
      K_CR:  nc = '0;
      K_LF: begin
        nc = '0;
        nr = nr + 1'b1;
      end
      K_PRINT: nc = nc + 1'b1;
      default: nc = {1'b0, col_r};
    endcase
    if (nc >= (COL_W+1)'(COLUMNS)) begin
      nc = '0;
      nr = nr + 1'b1;
    end
    nx_scroll = nr >= (ROW_W+1)'(ROWS);
    if (nx_scroll) nr = (ROW_W+1)'(ROWS - 1);
    nx_col = nc[COL_W-1:0];
    nx_row = nr[ROW_W-1:0];
  end

  assign pos_cur  = AW'(row_r * COLUMNS) + AW'(col_r);
  assign pos_nx   = AW'(nx_row * COLUMNS) + AW'(nx_col);
  assign read_ok  = 13'(q_rd.ent.read_index) < 13'(CELLS);
  assign is_print = q_rd.ent.kind == K_PRINT;

  always_comb begin
    put_res                 = '0;
    put_res.cursor_position = IDX_W'(pos_nx);
    put_res.cursor_col      = nx_col;
    put_res.cursor_row      = nx_row;
    put_res.scrolled        = nx_scroll;
    put_res.cell_written    = is_print;
    if (is_print) begin
      put_res.cell_index = IDX_W'(pos_cur);
      put_res.cell_value = q_rd.ent.cell_data;
    end
    read_res                 = '0;
    read_res.cursor_position = IDX_W'(pos_cur);
    read_res.cursor_col      = col_r;
    read_res.cursor_row      = row_r;
    read_res.cell_index      = q_rd.ent.read_index;
  end

  // store port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = k_r[AW-1:0];
    mem_wd = fill_val_r;
    mem_ra = AW'(q_rd.ent.read_index);
    unique case (state_r)
      S_IDLE: begin
        mem_we = q_pop && is_print;
        mem_wa = pos_cur;
        mem_wd = q_rd.ent.cell_data;
      end
      S_SCROLL: begin
        mem_we = k_r != '0;
        mem_wa = k_r[AW-1:0] - AW'(1);
        mem_wd = mem_rd_r;
        mem_ra = AW'(k_r + CW'(COLUMNS));
      end
      S_FILL:  mem_we = 1'b1;
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      k_r         <= '0;
      fill_val_r  <= BLANK_RESET;
      init_r      <= 1'b1;
      col_r       <= '0;
      row_r       <= '0;
      blank_r     <= BLANK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) blank_r <= cfg_ch.blank_cell;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            unique case (q_rd.ent.kind)
              K_CLEAR: begin
                col_r      <= '0;
                row_r      <= '0;
                res_r      <= '0;
                fill_val_r <= blank_r;
                k_r        <= '0;
                state_r    <= S_FILL;
              end
              K_READ: begin
                res_r   <= read_res;
                rd_ok_r <= read_ok;
                state_r <= S_READ;
              end
              default: begin
                col_r <= nx_col;
                row_r <= nx_row;
                if (nx_scroll) begin
                  res_r      <= put_res;
                  fill_val_r <= blank_r;
                  k_r        <= '0;
                  state_r    <= S_SCROLL;
                end else begin
                  out_r <= put_res;
                end
              end
            endcase
          end
        end
        S_READ: begin
          res_r.cell_value <= rd_ok_r ? mem_rd_r : '0;
          state_r          <= S_DONE;
        end
        S_SCROLL: begin
          if (k_r == CW'(LAST)) state_r <= S_FILL;
          else k_r <= k_r + 1'b1;
        end
        S_FILL: begin
          if (k_r == CW'(CELLS - 1)) begin
            init_r  <= 1'b0;
            state_r <= init_r ? S_IDLE : S_DONE;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_r   <= res_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.cursor_position = out_r.cursor_position;
  assign out_ch.cursor_col      = out_r.cursor_col;
  assign out_ch.cursor_row      = out_r.cursor_row;
  assign out_ch.scrolled        = out_r.scrolled;
  assign out_ch.cell_written    = out_r.cell_written;
  assign out_ch.cell_index      = out_r.cell_index;
  assign out_ch.cell_value      = out_r.cell_value;

`ifndef NO_ASSERTIONS
  a_cursor_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(col_r) < COLUMNS) && (32'(row_r) < ROWS))
    else $error("cursor outside screen");
  a_scroll_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.scrolled |-> 32'(out_r.cursor_row) == ROWS - 1)
    else $error("scroll reported off the last row");
  a_write_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> 32'(mem_wa) < CELLS)
    else $error("store write beyond last cell");
`endif

endmodule

// ===== rtl/core/text_console_cursor_scroll.sv =====
// text console engine: ROWS x COLUMNS cell store with cursor, scroll and clear
// throughput: one put per cycle while no scroll and the result receiver is ready; a scroll
// (one copy pass over the store, then a blank fill of the last row), a clear and a read
// pause the handling of further requests until their result is loaded
// reset: synchronous active-low rst_n; the store is then filled with 0x0F20 while
// in_ch.ready is low; config writes are taken throughout
`timescale 1ns / 1ps

module text_console_cursor_scroll #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  tccs_cmd_if.sink    in_ch,
  tccs_res_if.source  out_ch,
  tccs_cfg_if.sink    cfg_ch
);
  import tccs_pkg::*;

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;
  logic  init_busy;

  tccs_front u_front (
    .in_ch     (in_ch),
    .q_full    (q_full),
    .init_busy (init_busy),
    .q_wr      (q_wr)
  );

  tccs_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  tccs_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rd      (q_rd),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .cfg_ch    (cfg_ch),
    .out_ch    (out_ch)
  );

endmodule

// ===== test/text_console_cursor_scroll_tb.sv =====
// testbench for text_console_cursor_scroll: random and directed console requests
// checked field by field against a cursor and screen store predictor
// depends on tccs_pkg, the tccs channel interfaces and the block itself
`timescale 1ns / 1ps

module text_console_cursor_scroll_tb;
  import tccs_pkg::*;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int CELLS     = ROWS * COLUMNS;
  localparam int MAX_INDEX = 2047;
  localparam int LIMIT     = 16000000;
  localparam int PHASES    = 5;
  localparam int PHASE_REQUESTS = 290;

  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

  class screen_scoreboard;
    logic [CELL_W-1:0] cells [CELLS];
    int unsigned       col;
    int unsigned       row;
    logic [CELL_W-1:0] blank;
    res_t              expected_reports [$];
    int                errors;
    int                checked;

    function new();
      blank = BLANK_RESET;
      foreach (cells[i]) cells[i] = blank;
      col = 0;
      row = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_blank(logic [CELL_W-1:0] v);
      blank = v;
    endfunction

    function int unsigned cursor_index();
      return row * COLUMNS + col;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                               logic [ATTR_W-1:0] attr, logic [IDX_W-1:0] idx);
      res_t        r;
      int unsigned pos;
      r = '0;
      case (cmd)
        CMD_PUT: begin
          if (ch == CH_BS) begin
            if (col != 0) col--;
          end else if (ch == CH_TAB) begin
            col = (col + TAB_STEP) & ~(TAB_STEP - 1);
          end else if (ch == CH_CR) begin
            col = 0;
          end else if (ch == CH_LF) begin
            col = 0;
            row++;
          end else if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
            pos = cursor_index();
            cells[pos] = {attr, ch};
            r.cell_written = 1'b1;
            r.cell_index = IDX_W'(pos);
            r.cell_value = {attr, ch};
            col++;
          end
          if (col >= COLUMNS) begin
            col = 0;
            row++;
          end
          if (row >= ROWS) begin
            for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) cells[i] = cells[i + COLUMNS];
            for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) cells[i] = blank;
            row = ROWS - 1;
            r.scrolled = 1'b1;
          end
        end
        CMD_CLEAR: begin
          foreach (cells[i]) cells[i] = blank;
          col = 0;
          row = 0;
        end
        CMD_READ: begin
          r.cell_index = idx;
          r.cell_value = (idx < CELLS) ? cells[idx] : '0;
        end
        default: ;
      endcase
      r.cursor_position = IDX_W'(cursor_index());
      r.cursor_col = COL_W'(col);
      r.cursor_row = ROW_W'(row);
      expected_reports.push_back(r);
    endfunction

    task report(string msg);
      if (errors < 100) $display("mismatch: %s", msg);
      errors++;
    endtask

    task compare_field(string name, int unsigned got, int unsigned want);
      if (got != want)
        report($sformatf("result %0d %s: got 0x%0h, want 0x%0h", checked, name, got, want));
    endtask

    task check_result(res_t got);
      res_t want;
      if (expected_reports.size() == 0) begin
        report($sformatf("result with no request pending, cursor %0d", got.cursor_position));
        return;
      end
      want = expected_reports.pop_front();
      compare_field("cursor_position", got.cursor_position, want.cursor_position);
      compare_field("cursor_col", got.cursor_col, want.cursor_col);
      compare_field("cursor_row", got.cursor_row, want.cursor_row);
      compare_field("scrolled", got.scrolled, want.scrolled);
      compare_field("cell_written", got.cell_written, want.cell_written);
      compare_field("cell_index", got.cell_index, want.cell_index);
      compare_field("cell_value", got.cell_value, want.cell_value);
      checked++;
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   idle_on;
  bit   tx_quiet;
  bit   hold_request;
  bit   rx_hold;
  int   cycle_count;

  screen_scoreboard sb;

  tccs_cmd_if in_if ();
  tccs_res_if out_if ();
  tccs_cfg_if cfg_if ();

  text_console_cursor_scroll #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    rx_hold = 1'b0;
    wait (hold_request);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (400) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    int stall;
    int quiet_left;
    stall = 0;
    quiet_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
      end else if (idle_on && quiet_left == 0 && $urandom_range(0, 6) == 0) begin
        stall = $urandom_range(1, 11);
      end
      if (quiet_left > 0) quiet_left--;
      else if ($urandom_range(0, 199) == 0) quiet_left = $urandom_range(50, 300);
      out_if.ready = !rx_hold && stall == 0;
    end
  end

  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.cursor_position = out_if.cursor_position;
      got.cursor_col = out_if.cursor_col;
      got.cursor_row = out_if.cursor_row;
      got.scrolled = out_if.scrolled;
      got.cell_written = out_if.cell_written;
      got.cell_index = out_if.cell_index;
      got.cell_value = out_if.cell_value;
      sb.check_result(got);
    end
  end

  task issue_request(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                     input logic [ATTR_W-1:0] attr, input logic [IDX_W-1:0] idx);
    in_if.command = cmd;
    in_if.char_code = ch;
    in_if.attribute = attr;
    in_if.read_index = idx;
    in_if.valid = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(cmd, ch, attr, idx);
    @(negedge clk);
    if (idle_on && !tx_quiet && $urandom_range(0, 5) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
  endtask

  task write_blank(input logic [CELL_W-1:0] v);
    cfg_if.blank_cell = v;
    cfg_if.valid = 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    sb.set_blank(v);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task drain_reports();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task run_random(input int target);
    int                done_cnt;
    int                iter;
    int unsigned       pick;
    int unsigned       sel;
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
    done_cnt = 0;
    iter = 0;
    while (done_cnt < target) begin
      if (iter % 40 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
      iter++;
      pick = $urandom_range(0, 999);
      cmd = CMD_PUT;
      ch = CHAR_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
      idx = IDX_W'($urandom_range(0, MAX_INDEX));
      if (pick < 560) begin
        cmd = CMD_PUT;
      end else if (pick < 680) begin
        ch = CH_LF;
      end else if (pick < 710) begin
        ch = CH_CR;
      end else if (pick < 750) begin
        ch = CH_TAB;
      end else if (pick < 790) begin
        ch = CH_BS;
      end else if (pick < 830) begin
        ch = CHAR_W'($urandom_range(0, 255));
      end else if (pick < 950) begin
        cmd = CMD_READ;
        sel = $urandom_range(0, 9);
        if (sel < 5)
          idx = IDX_W'((sb.cursor_index() + CELLS - $urandom_range(1, 160)) % CELLS);
        else if (sel == 5) idx = IDX_W'($urandom_range(CELLS, MAX_INDEX));
        else idx = IDX_W'($urandom_range(0, CELLS - 1));
      end else if (pick < 954) begin
        cmd = CMD_CLEAR;
      end else if (pick < 975) begin
        cmd = CMD_RESERVED;
      end
      issue_request(cmd, ch, ATTR_W'($urandom_range(0, 255)), idx);
      done_cnt++;
    end
  endtask

  initial begin
    logic [CELL_W-1:0] phase_blank [PHASES];
    sb = new();
    rst_n = 1'b0;
    idle_on = 1'b1;
    tx_quiet = 1'b0;
    hold_request = 1'b0;
    in_if.valid = 1'b0;
    in_if.command = CMD_PUT;
    in_if.char_code = '0;
    in_if.attribute = '0;
    in_if.read_index = '0;
    cfg_if.valid = 1'b0;
    cfg_if.blank_cell = '0;
    phase_blank[0] = BLANK_RESET;
    phase_blank[1] = 16'h0000;
    phase_blank[2] = 16'hFFFF;
    phase_blank[3] = CELL_W'($urandom_range(0, 65535));
    phase_blank[4] = CELL_W'($urandom_range(0, 65535));
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // reset contents, edges of the store and beyond it
    issue_request(CMD_READ, 8'h00, 8'h00, 11'd0);
    issue_request(CMD_READ, 8'hFF, 8'hFF, 11'd1999);
    issue_request(CMD_READ, 8'h00, 8'h00, 11'd2047);
    // printable extremes, ignored codes, backspace and return
    issue_request(CMD_PUT, 8'h41, 8'h00, 11'd0);
    issue_request(CMD_PUT, CH_PRINT_HI, 8'hFF, 11'd2047);
    issue_request(CMD_PUT, CH_PRINT_LO, 8'h5A, 11'd0);
    issue_request(CMD_PUT, 8'h1F, 8'hFF, 11'd0);
    issue_request(CMD_PUT, 8'hFF, 8'hFF, 11'd0);
    issue_request(CMD_PUT, 8'h00, 8'h00, 11'd0);
    issue_request(CMD_PUT, 8'h80, 8'hA5, 11'd0);
    issue_request(CMD_PUT, CH_BS, 8'h00, 11'd0);
    issue_request(CMD_PUT, CH_CR, 8'h00, 11'd0);
    issue_request(CMD_PUT, CH_BS, 8'h00, 11'd0);
    issue_request(CMD_READ, 8'h00, 8'h00, 11'd1);
    issue_request(CMD_RESERVED, 8'hFF, 8'hFF, 11'd2047);
    // tabs run past the last column and wrap
    repeat (10) issue_request(CMD_PUT, CH_TAB, 8'h00, 11'd0);
    issue_request(CMD_PUT, CH_LF, 8'h00, 11'd0);
    issue_request(CMD_CLEAR, 8'h00, 8'h00, 11'd0);
    issue_request(CMD_READ, 8'h00, 8'h00, 11'd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        in_if.valid = 1'b0;
        drain_reports();
        // let any clear or scroll pass finish before touching the register
        repeat (CELLS + 16) @(negedge clk);
        write_blank(phase_blank[ph]);
      end
      if (ph == 1) hold_request = 1'b1;
      if (ph == PHASES - 1) idle_on = 1'b0;
      if (ph == 2 || ph == PHASES - 1) issue_request(CMD_CLEAR, 8'h00, 8'h00, 11'd0);
      run_random(PHASE_REQUESTS);
    end

    in_if.valid = 1'b0;
    drain_reports();
    repeat (16) @(negedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
